// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared property templates clocked on clk and quiet while rst is high.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/brfifo_pkg.sv =====
// ---------------------------------------------------------------------------
// brfifo_pkg
// Types and defaults for the byte ring FIFO with read mark.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package brfifo_pkg;

  localparam int unsigned BRF_DEPTH     = 256;
  localparam int unsigned BRF_MAX_BURST = 64;
  localparam int unsigned BRF_BYTE_W    = 8;

  typedef enum logic [2:0] {
    OP_WRITE  = 3'd0,
    OP_READ   = 3'd1,
    OP_BURST  = 3'd2,
    OP_PEEK   = 3'd3,
    OP_LPEEK  = 3'd4,
    OP_COMMIT = 3'd5,
    OP_RESET  = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_FETCH = 2'b10
  } state_t;

endpackage

// ===== hw/rtl/brfifo_ram.sv =====
// ---------------------------------------------------------------------------
// brfifo_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module brfifo_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/byte_ring_fifo_with_read_mark.sv =====
// ---------------------------------------------------------------------------
// byte_ring_fifo_with_read_mark
// Power-of-two byte ring buffer with a read mark for in-place segment reads.
// ---------------------------------------------------------------------------
//
// Channel   Dir  Handshake          Payload
// s_*       in   tvalid / tready    tuser = operation, tdata = wr_byte, req_length
// m_*       out  tvalid / tready    tuser = status, tdata = rd_byte .. free_space,
//                                   tlast = last result of the command
//
// Timing: write, peek, commit, reset and refused commands have their result
// registered and shown in the cycle after the transfer. A read or burst read
// first fetches the byte at the read index through the registered read port
// of the byte RAM, then delivers one byte per cycle while m_tready is high.
// Reset: rst is synchronous; it clears the indexes, the mark, the burst
// counter and the output valid. The byte RAM is not cleared.
// Stalls: the output register frees the input side as soon as a result is
// taken; a stalled consumer holds a burst in place with the RAM data kept.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module byte_ring_fifo_with_read_mark
  import brfifo_pkg::*;
#(
  parameter int unsigned DEPTH     = BRF_DEPTH,
  parameter int unsigned MAX_BURST = BRF_MAX_BURST
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] wr_byte, [15:8] req_length
  input  logic [2:0]  s_tuser,   // [2:0] operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [7:0] rd_byte, [15:8] seg_start,
                                 // [23:16] seg_length, [31:24] fill_count,
                                 // [39:32] free_space
  output logic        m_tuser,   // [0] status
  output logic        m_tlast
);

  // Index width, width of the burst counter, and a compare width that holds
  // any index, any request and their sum without overflow.
  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned BW = $clog2(MAX_BURST + 1);
  localparam int unsigned CW = ((IW > 8) ? IW : 8) + 1;

  localparam logic [IW-1:0] IDX_ONE  = IW'(1);
  localparam logic [CW-1:0] MASK_EXT = CW'(DEPTH - 1);
  localparam logic [CW-1:0] BURST_EXT = CW'(MAX_BURST);

  // Ring state. The bytes themselves live in the RAM below.
  state_t        state, state_next;
  logic [IW-1:0] r_idx, r_next;
  logic [IW-1:0] w_idx, w_next;
  logic [IW-1:0] mark, mark_next;
  logic [BW-1:0] cnt, cnt_next;

  // Input fields.
  op_t       op;
  logic [7:0] wr_byte;
  logic [7:0] req_length;

  assign op         = op_t'(s_tuser);
  assign wr_byte    = s_tdata[7:0];
  assign req_length = s_tdata[15:8];

  logic out_free;
  logic accept;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE) && out_free;
  assign accept   = s_tvalid && s_tready;

  // Byte RAM. A write happens only on the transfer of a write command, and
  // reads are issued only for read commands or while a burst runs, so a
  // write and a read never meet in the same cycle and no forwarding is needed.
  logic          ram_we;
  logic          ram_re;
  logic [IW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  brfifo_ram #(
    .WIDTH (BRF_BYTE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (w_idx),
    .wr_data (wr_byte),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Occupancy now, and measured from the mark for the unlimited peek.
  logic [IW-1:0] fill_cur;
  logic [IW-1:0] fill_mark;
  logic [CW-1:0] fill_ext;
  logic [CW-1:0] req_ext;
  logic [CW-1:0] lim_ext;
  logic [CW-1:0] burst_n;

  assign fill_cur  = w_idx - r_idx;
  assign fill_mark = w_idx - mark;
  assign fill_ext  = {{(CW-IW){1'b0}}, fill_cur};
  assign req_ext   = {{(CW-8){1'b0}}, req_length};
  assign lim_ext   = (fill_ext > req_ext) ? req_ext : fill_ext;
  assign burst_n   = (lim_ext > BURST_EXT) ? BURST_EXT : lim_ext;

  // Segment path shared by both peeks. The unlimited peek starts at the mark
  // (read index rewound there) and wants everything held from it; the limited
  // peek starts at the read index. A segment that would pass the ring end is
  // cut there, and the mark then wraps to zero.
  logic [IW-1:0] seg_start;
  logic [IW-1:0] seg_want;
  logic [CW-1:0] seg_sum;
  logic          seg_wrap;
  logic [IW-1:0] seg_len;
  logic [IW-1:0] seg_mark;

  assign seg_start = (op == OP_PEEK) ? mark : r_idx;
  assign seg_want  = (op == OP_PEEK) ? fill_mark : lim_ext[IW-1:0];
  assign seg_sum   = {{(CW-IW){1'b0}}, seg_start} + {{(CW-IW){1'b0}}, seg_want};
  assign seg_wrap  = seg_sum > MASK_EXT;
  // When the segment wraps the start is never zero, so the distance to the
  // ring end is the two's complement of the start.
  assign seg_len   = seg_wrap ? (~seg_start + IDX_ONE) : seg_want;
  assign seg_mark  = seg_wrap ? '0 : seg_sum[IW-1:0];

  // Result being formed this cycle.
  logic          load;
  logic [7:0]    res_byte;
  logic          res_status;
  logic [IW-1:0] res_start;
  logic [IW-1:0] res_len;
  logic          res_last;

  always_comb begin
    state_next = state;
    r_next     = r_idx;
    w_next     = w_idx;
    mark_next  = mark;
    cnt_next   = cnt;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_raddr  = r_idx;
    load       = 1'b0;
    res_byte   = '0;
    res_status = 1'b0;
    res_start  = '0;
    res_len    = '0;
    res_last   = 1'b1;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_WRITE: begin
              // One slot always stays empty, so full means the next write
              // index would land on the read index.
              if ((w_idx + IDX_ONE) != r_idx) begin
                ram_we = 1'b1;
                w_next = w_idx + IDX_ONE;
              end else begin
                res_status = 1'b1;
              end
              load = 1'b1;
            end
            OP_READ: begin
              if (fill_cur != '0) begin
                ram_re     = 1'b1;
                cnt_next   = BW'(1);
                state_next = ST_FETCH;
              end else begin
                res_status = 1'b1;
                load       = 1'b1;
              end
            end
            OP_BURST: begin
              if (burst_n == '0) begin
                // Nothing to pop: a single closing result, refused only
                // when the ring itself was empty.
                mark_next  = r_idx;
                res_status = (fill_cur == '0);
                load       = 1'b1;
              end else begin
                ram_re     = 1'b1;
                cnt_next   = burst_n[BW-1:0];
                state_next = ST_FETCH;
              end
            end
            OP_PEEK, OP_LPEEK: begin
              if (op == OP_PEEK) begin
                r_next = mark;
              end
              mark_next = seg_mark;
              res_start = seg_start;
              res_len   = seg_len;
              load      = 1'b1;
            end
            OP_COMMIT: begin
              r_next = mark;
              load   = 1'b1;
            end
            OP_RESET: begin
              // The mark survives a reset command.
              r_next = '0;
              w_next = '0;
              load   = 1'b1;
            end
            default: begin
              res_status = 1'b1;
              load       = 1'b1;
            end
          endcase
        end
      end
      ST_FETCH: begin
        // The RAM holds the byte at the read index. Pop it once the output
        // register can take it and fetch the next byte behind it.
        if (out_free) begin
          load     = 1'b1;
          res_byte = ram_rdata;
          r_next   = r_idx + IDX_ONE;
          cnt_next = cnt - BW'(1);
          if (cnt == BW'(1)) begin
            mark_next  = r_idx + IDX_ONE;
            state_next = ST_IDLE;
          end else begin
            res_last  = 1'b0;
            ram_re    = 1'b1;
            ram_raddr = r_idx + IDX_ONE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Counts reported with each result reflect the state after that result.
  logic [IW-1:0] fill_res;
  logic [IW-1:0] free_res;
  logic [IW+7:0] fill_pad;
  logic [IW+7:0] free_pad;
  logic [IW+7:0] start_pad;
  logic [IW+7:0] len_pad;

  assign fill_res  = w_next - r_next;
  assign free_res  = ~fill_res;
  assign fill_pad  = {8'd0, fill_res};
  assign free_pad  = {8'd0, free_res};
  assign start_pad = {8'd0, res_start};
  assign len_pad   = {8'd0, res_len};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      r_idx <= '0;
      w_idx <= '0;
      mark  <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      r_idx <= r_next;
      w_idx <= w_next;
      mark  <= mark_next;
      cnt   <= cnt_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {free_pad[7:0], fill_pad[7:0], len_pad[7:0], start_pad[7:0], res_byte};
      m_tuser <= res_status;
      m_tlast <= res_last;
    end
  end

  // A burst in flight always has a byte left to deliver.
  `ASSERT_SAME(a_fetch_cnt, state == ST_FETCH, cnt != '0, "fetch state with empty burst count")

  // A refused write leaves the write index where it was.
  `ASSERT_NEXT(a_full_hold, accept && (op == OP_WRITE) && ((w_idx + IDX_ONE) == r_idx),
    $stable(w_idx), "write index moved on a full ring")

  // After the final byte of a read, the mark sits on the read index.
  `ASSERT_NEXT(a_mark_sync, (state == ST_FETCH) && out_free && (cnt == BW'(1)),
    (mark == r_idx) && (state == ST_IDLE), "mark not set to read index after read")

endmodule
